### design/lfsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_pkg
// Shared types, constants and helper functions of the latest-frame slot
// manager: beat layouts, slot entry, result record and slot-mask helpers.
// ----------------------------------------------------------------------------
package lfsm_pkg;

  // Table geometry
  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned MIN_SLOTS = 2;
  localparam int unsigned IDX_W     = 4;   // slot index field
  localparam int unsigned CNT_W     = 5;   // slot count and ready count fields
  localparam int unsigned SEQ_W     = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned GRP_W     = 4;   // bits per group in the mask helpers
  localparam int unsigned GROUPS    = MAX_SLOTS / GRP_W;

  // Port widths
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned IN_TDATA_W  = 256;
  localparam int unsigned OUT_TDATA_W = 400;

  typedef logic [IDX_W-1:0] slot_idx_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_SLOT_COUNT = 1'b0,
    REG_SLOT_SIZE  = 1'b1
  } reg_idx_e;

  // Frame metadata, last declared field in the lowest bits
  typedef struct packed {
    logic signed [WORD_W-1:0] transfer_code;
    logic [WORD_W-1:0]        color_matrix;
    logic signed [SEQ_W-1:0]  time_stamp;
    logic [WORD_W-1:0]        row_stride;
    logic [WORD_W-1:0]        frame_height;
    logic [WORD_W-1:0]        frame_width;
    logic [WORD_W-1:0]        byte_length;
  } meta_t;

  typedef struct packed {
    opcode_e op;
    meta_t   meta;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  slot_count;
    logic [WORD_W-1:0] slot_size;
  } cfg_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    meta_t            meta;
  } entry_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    entry_t    data;
  } mem_wr_t;

  // Result fields, last declared field in the lowest bits
  typedef struct packed {
    meta_t            meta;
    logic [CNT_W-1:0] ready_slots;
    logic [SEQ_W-1:0] dropped_total;
    logic [SEQ_W-1:0] frame_sequence;
    slot_idx_t        slot_index;
  } result_t;

  typedef struct packed {
    logic    valid;
    status_e status;
    result_t data;
  } res_t;

  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

  // Last slot in use, with the count saturated into the legal range
  function automatic slot_idx_t active_last(input logic [CNT_W-1:0] cnt);
    slot_idx_t r;
    if (cnt < CNT_W'(MIN_SLOTS)) begin
      r = IDX_W'(MIN_SLOTS - 1);
    end else if (cnt > CNT_W'(MAX_SLOTS)) begin
      r = IDX_W'(MAX_SLOTS - 1);
    end else begin
      r = IDX_W'(cnt - 1'b1);
    end
    return r;
  endfunction

  // Count set bits, group by group
  function automatic logic [CNT_W-1:0] pop_count(input logic [MAX_SLOTS-1:0] v);
    logic [CNT_W-1:0] sum;
    logic [2:0]       part;
    sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      part = 3'(v[GRP_W*g]) + 3'(v[GRP_W*g+1]) + 3'(v[GRP_W*g+2]) + 3'(v[GRP_W*g+3]);
      sum  = sum + CNT_W'(part);
    end
    return sum;
  endfunction

  // Lowest set bit: pick the group first, then the bit within it
  function automatic slot_idx_t lowest_set(input logic [MAX_SLOTS-1:0] v);
    logic [1:0]       grp;
    logic [1:0]       pos;
    logic [GRP_W-1:0] part;
    grp = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (|v[GRP_W*g +: GRP_W]) grp = 2'(g);
    end
    part = v[{grp, 2'b00} +: GRP_W];
    pos  = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (part[b]) pos = 2'(b);
    end
    return {grp, pos};
  endfunction

endpackage

### design/lfsm_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_slot_mem
// Slot table storage: sequence number and metadata of every slot, one write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfsm_slot_mem (
  input  logic               clk_i,
  input  lfsm_pkg::mem_wr_t  wr_i,
  input  lfsm_pkg::slot_idx_t raddr_i,
  output lfsm_pkg::entry_t   rdata_o
);
  import lfsm_pkg::*;

  entry_t mem_q [MAX_SLOTS];
  entry_t rdata_q;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/lfsm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_seq
// Operation sequencer: walks the slot table one entry a cycle through the
// memory read port and one shared 64-bit magnitude comparator, keeps the
// ready bits and the sequence and drop counters, and forms the result.
// ----------------------------------------------------------------------------
module lfsm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfsm_pkg::cfg_t      cfg_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  lfsm_pkg::req_t      req_i,
  output lfsm_pkg::res_t      res_o,
  input  logic                res_take_i,
  output lfsm_pkg::mem_wr_t   mem_wr_o,
  output lfsm_pkg::slot_idx_t mem_raddr_o,
  input  lfsm_pkg::entry_t    mem_rdata_i
);
  import lfsm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DROP   = 7'b0001000,
    S_COMMIT = 7'b0010000,
    S_FETCH  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  req_t                 req_q;
  logic [MAX_SLOTS-1:0] ready_q, ready_d;
  logic [SEQ_W-1:0]     next_seq_q, next_seq_d;
  logic [SEQ_W-1:0]     drop_q, drop_d;
  logic [SEQ_W-1:0]     best_q, best_d;
  logic [SEQ_W-1:0]     res_seq_q, res_seq_d;
  logic                 found_q, found_d;
  slot_idx_t            sel_q, sel_d;
  status_e              status_q, status_d;
  slot_idx_t            rd_idx_q, rd_idx_d;
  logic                 issue_done_q, issue_done_d;
  logic                 cmp_vld_q, cmp_vld_d;
  slot_idx_t            cmp_idx_q, cmp_idx_d;

  slot_idx_t            last_idx;
  logic [MAX_SLOTS-1:0] act_mask;
  logic [MAX_SLOTS-1:0] ready_act;
  logic [MAX_SLOTS-1:0] free_act;
  logic                 start;
  logic                 scanning;
  logic                 issuing;
  logic                 scan_last;
  logic                 take;
  logic [SEQ_W-1:0]     cmp_a, cmp_b;
  logic                 cmp_lt;
  logic                 read_ok;

  // Slots in use
  assign last_idx = active_last(cfg_i.slot_count);
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      act_mask[i] = (IDX_W'(i) <= last_idx);
    end
  end
  assign ready_act = ready_q & act_mask;
  assign free_act  = ~ready_q & act_mask;

  assign req_ready_o = (state_q == S_IDLE);
  assign start       = req_valid_i && req_ready_o;
  assign scanning    = (state_q == S_SCAN) || (state_q == S_DROP);
  assign issuing     = scanning && !issue_done_q;
  assign scan_last   = cmp_vld_q && (cmp_idx_q == last_idx);

  // Shared comparator: length check, then slot sequence against the best so far
  always_comb begin
    cmp_a = mem_rdata_i.seq;
    cmp_b = best_q;
    if (state_q == S_CHECK) begin
      cmp_a = {{(SEQ_W-WORD_W){1'b0}}, cfg_i.slot_size};
      cmp_b = {{(SEQ_W-WORD_W){1'b0}}, req_q.meta.byte_length};
    end
  end
  assign cmp_lt = (cmp_a < cmp_b);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    next_seq_d   = next_seq_q;
    drop_d       = drop_q;
    best_d       = best_q;
    res_seq_d    = res_seq_q;
    found_d      = found_q;
    sel_d        = sel_q;
    status_d     = status_q;
    rd_idx_d     = rd_idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = issuing;
    cmp_idx_d    = rd_idx_q;
    take         = 1'b0;

    // Issue one slot read per cycle while scanning
    if (issuing) begin
      rd_idx_d = rd_idx_q + 1'b1;
      if (rd_idx_q == last_idx) issue_done_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_CHECK;
      end
      S_CHECK: begin
        found_d      = 1'b0;
        status_d     = ST_OK;
        rd_idx_d     = '0;
        issue_done_d = 1'b0;
        if (req_q.op == OP_WRITE) begin
          if (cmp_lt) begin
            status_d  = ST_OVERSIZE;
            res_seq_d = '0;
            state_d   = S_DONE;
          end else if (|free_act) begin
            sel_d   = lowest_set(free_act);
            state_d = S_COMMIT;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          if (ready_act == '0) begin
            status_d  = ST_EMPTY;
            res_seq_d = '0;
            state_d   = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Oldest for a write (strict, lowest index wins), newest for a read
        if (cmp_vld_q && ready_q[cmp_idx_q]) begin
          take = !found_q || ((req_q.op == OP_WRITE) ? cmp_lt : !cmp_lt);
        end
        if (take) begin
          found_d = 1'b1;
          best_d  = mem_rdata_i.seq;
          sel_d   = cmp_idx_q;
        end
        if (scan_last) begin
          rd_idx_d     = '0;
          issue_done_d = 1'b0;
          if (req_q.op == OP_WRITE) begin
            drop_d  = drop_q + 1'b1;
            state_d = S_COMMIT;
          end else begin
            state_d = S_DROP;
          end
        end
      end
      S_DROP: begin
        // Free every older ready slot, one drop each
        if (cmp_vld_q && ready_q[cmp_idx_q] && (cmp_idx_q != sel_q) && cmp_lt) begin
          ready_d[cmp_idx_q] = 1'b0;
          drop_d             = drop_q + 1'b1;
        end
        if (scan_last) begin
          ready_d[sel_q] = 1'b0;
          res_seq_d      = best_q;
          state_d        = S_FETCH;
        end
      end
      S_COMMIT: begin
        next_seq_d     = next_seq_q + 1'b1;
        res_seq_d      = next_seq_q + 1'b1;
        ready_d[sel_q] = 1'b1;
        state_d        = S_DONE;
      end
      S_FETCH: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ready_q      <= '0;
      next_seq_q   <= '0;
      drop_q       <= '0;
      found_q      <= 1'b0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      rd_idx_q     <= '0;
    end else begin
      state_q      <= state_d;
      ready_q      <= ready_d;
      next_seq_q   <= next_seq_d;
      drop_q       <= drop_d;
      found_q      <= found_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      rd_idx_q     <= rd_idx_d;
    end
  end

  // Working values
  always_ff @(posedge clk_i) begin
    if (start) req_q <= req_i;
    best_q    <= best_d;
    res_seq_q <= res_seq_d;
    sel_q     <= sel_d;
    status_q  <= status_d;
    cmp_idx_q <= cmp_idx_d;
  end

  // Memory ports
  assign mem_raddr_o        = scanning ? rd_idx_q : sel_q;
  assign mem_wr_o.en        = (state_q == S_COMMIT);
  assign mem_wr_o.addr      = sel_q;
  assign mem_wr_o.data.seq  = next_seq_q + 1'b1;
  assign mem_wr_o.data.meta = req_q.meta;

  // Result record
  assign read_ok = (req_q.op == OP_READ) && (status_q == ST_OK);
  always_comb begin
    res_o.valid               = (state_q == S_DONE);
    res_o.status              = status_q;
    res_o.data.slot_index     = (status_q == ST_OK) ? sel_q : '0;
    res_o.data.frame_sequence = res_seq_q;
    res_o.data.dropped_total  = drop_q;
    res_o.data.ready_slots    = pop_count(ready_act);
    res_o.data.meta           = read_ok ? mem_rdata_i.meta : '0;
  end

  // Checks
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing |-> (rd_idx_q <= last_idx))
    else $error("slot scan ran past the last slot in use");

  a_commit_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> ready_q[$past(sel_q)])
    else $error("written slot not marked ready");

  a_read_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && read_ok) |-> !ready_q[sel_q])
    else $error("slot returned by a read is still ready");

  a_drop_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drop_q == $past(drop_q)) || (drop_q == $past(drop_q) + 64'd1))
    else $error("drop counter moved by more than one");

endmodule

### design/latest_frame_slot_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latest_frame_slot_manager_unit
// Latest-frame slot manager: bookkeeping of a table of frame slots for a
// producer that writes frames and a consumer that reads the newest one.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per beat: tuser is the opcode (write frame or
//   read latest), tdata the frame length and metadata. m_axis returns one
//   result beat per request: tuser is the status, tdata the slot index,
//   sequence, drop total, ready count and, for a read, the stored metadata.
//   The APB port sets slot_count and slot_size; write it only while idle.
// Flow (n = slots in use, 2..16), from accept beat to result beat:
//   write into a free slot: check, then commit; oversized write or empty
//   read: check only; write that overwrites the oldest slot: check, a scan
//   of the n slots, commit; read latest: check, scan, drop scan, fetch.
//   The table is walked one slot a cycle over the single memory read port
//   and one shared comparator; a new request is taken in the cycle after the
//   previous result moves into the output register.
// Reset clears the ready bits and counters (every slot free), slot_count 4,
//   slot_size all ones. A stalled m_axis holds its beat; one further request
//   is accepted and waits complete until the output register frees.
// ----------------------------------------------------------------------------
module latest_frame_slot_manager_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // s_axis_tdata: byte_length, frame_width, frame_height, row_stride,
  //               time_stamp, color_matrix, transfer_code
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [lfsm_pkg::IN_TDATA_W-1:0]        s_axis_tdata_i,
  // s_axis_tuser: opcode
  input  logic                                   s_axis_tuser_i,
  // m_axis_tdata: slot_index, frame_sequence, dropped_total, ready_slots,
  //               out_length, out_width, out_height, out_stride,
  //               out_time_stamp, out_color_matrix, out_transfer_code, zero pad
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [lfsm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  // m_axis_tuser: status
  output logic [1:0]                             m_axis_tuser_o,
  // APB configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lfsm_pkg::APB_AW-1:0]            paddr,
  input  logic [lfsm_pkg::APB_DW-1:0]            pwdata,
  output logic [lfsm_pkg::APB_DW-1:0]            prdata,
  output logic                                   pready
);
  import lfsm_pkg::*;

  cfg_t      cfg_q;
  reg_idx_e  reg_sel;
  logic      cfg_wr;
  req_t      req;
  res_t      res;
  logic      out_free;
  logic      m_valid_q;
  status_e   m_status_q;
  result_t   m_data_q;
  mem_wr_t   mem_wr;
  slot_idx_t mem_raddr;
  entry_t    mem_rdata;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_count <= CNT_W'(4);
      cfg_q.slot_size  <= '1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SLOT_COUNT: cfg_q.slot_count <= pwdata[CNT_W-1:0];
        REG_SLOT_SIZE:  cfg_q.slot_size  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SLOT_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_q.slot_count};
      REG_SLOT_SIZE:  prdata = cfg_q.slot_size;
      default:        prdata = '0;
    endcase
  end

  // Unpack the request beat
  assign req.op   = opcode_e'(s_axis_tuser_i);
  assign req.meta = meta_t'(s_axis_tdata_i);

  lfsm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_o       (res),
    .res_take_i  (out_free),
    .mem_wr_o    (mem_wr),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lfsm_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load a finished result when empty or being drained
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.valid && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      m_status_q <= res.status;
      m_data_q   <= res.data;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, m_data_q};

endmodule
